>>> hdl/tclw_pkg.sv
package tclw_pkg;

  localparam int DefColumns = 20;
  localparam int DefRows = 4;

  localparam logic [7:0] CmdClear = 8'h01;
  localparam logic [7:0] CmdScrollLeft = 8'h18;
  localparam logic [7:0] CmdScrollRight = 8'h1c;
  localparam logic [7:0] CmdAddrBase = 8'h80;
  localparam logic [7:0] OddRowOffset = 8'd64;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] ChLt = 8'h3c;
  localparam logic [7:0] ChGt = 8'h3e;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7e;

  // one display write queued between the parser and the nibble sequencer
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } wr_t;

  // up to six writes per byte (flush of a five byte prefix plus address)
  localparam int MaxWrites = 6;

  typedef struct packed {
    logic [MaxWrites-1:0] vld;
    wr_t [MaxWrites-1:0]  wr;
  } batch_t;

  typedef enum logic [5:0] {
    PH_PREFIX  = 6'b000001,
    PH_LINE    = 6'b000010,
    PH_COL     = 6'b000100,
    PH_SCR     = 6'b001000,
    PH_TEXT    = 6'b010000,
    PH_DISCARD = 6'b100000
  } phase_t;

  function automatic logic [7:0] word_chr(input logic [2:0] w, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (w)
      3'd0: case (i) 3'd0: r = "<"; 3'd1: r = "c"; 3'd2: r = "l"; 3'd3: r = "r";
                     default: r = 8'h00; endcase
      3'd1: case (i) 3'd0: r = "<"; 3'd1: r = "p"; 3'd2: r = "o"; 3'd3: r = "s";
                     3'd4: r = " "; default: r = 8'h00; endcase
      3'd2: case (i) 3'd0: r = "<"; 3'd1: r = "s"; 3'd2: r = "c"; 3'd3: r = "r";
                     3'd4: r = " "; default: r = 8'h00; endcase
      3'd3: case (i) 3'd0: r = "l"; 3'd1: r = "e"; 3'd2: r = "f"; 3'd3: r = "t";
                     default: r = 8'h00; endcase
      3'd4: case (i) 3'd0: r = "r"; 3'd1: r = "i"; 3'd2: r = "g"; 3'd3: r = "h";
                     3'd4: r = "t"; default: r = 8'h00; endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/tclw_front.sv
module tclw_front import tclw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS = DefRows
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       b_valid,
  input  logic       b_ready,
  output batch_t     b_data
);

  localparam int CW = $clog2(COLUMNS + 1);

  phase_t     phase, phase_next;
  logic [7:0] pstore [5];
  logic [7:0] pstore_next [5];
  logic [2:0] pcount, pcount_next;
  logic [2:0] flen, flen_next;
  // digit codes below '0' go negative; two column digits reach -528..2277
  logic signed [12:0] acc, acc_next;
  logic signed [8:0]  prow, prow_next;
  logic [1:0] wflags, wflags_next;
  logic [1:0] crow, crow_next;
  logic [CW-1:0] ccol, ccol_next;
  batch_t     bt;
  logic       bvld;

  assign in_ready = !bvld || b_ready;
  assign b_valid = bvld;

  always_comb begin
    logic [7:0] b;
    logic       eom;
    int         n;
    logic       m_clr, m_pos, m_scr, is_clr;
    logic [7:0] sb;
    logic signed [12:0] r, c, dig;
    logic [7:0] addr;
    logic       done;
    b = data_byte;
    eom = end_of_message;
    n = 0;
    done = 1'b0;
    phase_next = phase;
    for (int i = 0; i < 5; i++) pstore_next[i] = pstore[i];
    pcount_next = pcount;
    flen_next = flen;
    acc_next = acc;
    prow_next = prow;
    wflags_next = wflags;
    crow_next = crow;
    ccol_next = ccol;
    bt = '0;
    m_clr = 1'b0; m_pos = 1'b0; m_scr = 1'b0; is_clr = 1'b0;
    r = '0; c = '0; addr = '0; sb = '0;
    dig = 13'(b) - 13'(DigitBase);

    // emitting helpers are expanded inline as macros are not used
    case (phase)
      PH_PREFIX: begin
        if (b == 8'h00 || b == ChGt) begin
          is_clr = (pcount == 3'd4);
          for (int i = 0; i < 4; i++)
            if (pstore[i] != word_chr(3'd0, 3'(i))) is_clr = 1'b0;
          if (is_clr) begin
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdClear, last: 1'b0}; n++;
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdAddrBase, last: 1'b0}; n++;
            crow_next = '0; ccol_next = '0;
            phase_next = (b == ChGt) ? PH_TEXT : PH_DISCARD;
          end else begin
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdAddrBase, last: 1'b0}; n++;
            crow_next = '0; ccol_next = '0;
            phase_next = PH_TEXT;
            for (int i = 0; i < 6; i++) begin
              sb = (i < 5) ? pstore[i > 4 ? 0 : i] : b;
              if ((i < 5 && 3'(i) < pcount) || i == 5) begin
                if (!done) begin
                  if (sb == 8'h00) begin
                    phase_next = PH_DISCARD; done = 1'b1;
                  end else if (sb >= ChSpace && sb <= ChTilde) begin
                    bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b1, value: sb, last: 1'b0}; n++;
                    ccol_next = ccol_next + CW'(1);
                  end
                end
              end
            end
          end
          done = 1'b1;
        end
        if (!done) begin
          if (pcount < 3'd5) begin
            pstore_next[pcount] = b;
            pcount_next = pcount + 3'd1;
          end
          m_clr = (pcount_next <= 3'd4);
          m_pos = 1'b1; m_scr = 1'b1;
          for (int i = 0; i < 5; i++) begin
            if (3'(i) < pcount_next) begin
              if (i < 4 && pstore_next[i] != word_chr(3'd0, 3'(i))) m_clr = 1'b0;
              if (pstore_next[i] != word_chr(3'd1, 3'(i))) m_pos = 1'b0;
              if (pstore_next[i] != word_chr(3'd2, 3'(i))) m_scr = 1'b0;
            end
          end
          if (pcount_next == 3'd5 && m_pos) begin
            phase_next = PH_LINE; flen_next = '0; acc_next = '0;
          end else if (pcount_next == 3'd5 && m_scr) begin
            phase_next = PH_SCR; flen_next = '0; wflags_next = 2'b11;
          end else if (pcount_next == 3'd5 || !(m_clr || m_pos || m_scr)) begin
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdAddrBase, last: 1'b0}; n++;
            crow_next = '0; ccol_next = '0;
            phase_next = PH_TEXT;
            for (int i = 0; i < 5; i++) begin
              if (3'(i) < pcount_next && !done) begin
                if (pstore_next[i] == 8'h00) begin
                  phase_next = PH_DISCARD; done = 1'b1;
                end else if (pstore_next[i] >= ChSpace && pstore_next[i] <= ChTilde) begin
                  bt.vld[n] = 1'b1;
                  bt.wr[n] = '{rs: 1'b1, value: pstore_next[i], last: 1'b0}; n++;
                  ccol_next = ccol_next + CW'(1);
                end
              end
            end
          end else if (eom) begin
            if (m_clr && pcount_next == 3'd4) begin
              bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdClear, last: 1'b0}; n++;
              bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdAddrBase, last: 1'b0}; n++;
            end else begin
              bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdAddrBase, last: 1'b0}; n++;
              for (int i = 0; i < 5; i++) begin
                if (3'(i) < pcount_next && !done) begin
                  if (pstore_next[i] == 8'h00) done = 1'b1;
                  else if (pstore_next[i] >= ChSpace && pstore_next[i] <= ChTilde) begin
                    bt.vld[n] = 1'b1;
                    bt.wr[n] = '{rs: 1'b1, value: pstore_next[i], last: 1'b0}; n++;
                  end
                end
              end
            end
          end
        end
      end
      PH_LINE: begin
        r = 13'(ROWS); c = 13'(COLUMNS); // placeholders overwritten below
        if (b == ChComma) begin
          prow_next = acc[8:0]; acc_next = '0; flen_next = '0; phase_next = PH_COL;
          if (eom) begin r = acc; c = '0; done = 1'b1; end
        end else if (b == 8'h00) begin
          r = acc; c = '0; done = 1'b1; phase_next = PH_DISCARD;
        end else if (flen >= 3'd1) begin
          phase_next = PH_DISCARD;
        end else begin
          acc_next = dig; flen_next = 3'd1;
          if (eom) begin r = acc_next; c = '0; done = 1'b1; end
        end
        if (!done && eom && phase_next == PH_LINE) begin r = acc; c = '0; done = 1'b1; end
      end
      PH_COL: begin
        if (b == ChGt || b == 8'h00) begin
          r = 13'(prow); c = acc; done = 1'b1;
          phase_next = (b == ChGt) ? PH_TEXT : PH_DISCARD;
        end else if (flen >= 3'd2) begin
          phase_next = PH_DISCARD;
        end else begin
          acc_next = acc * 13'sd10 + dig;
          flen_next = flen + 3'd1;
          if (eom) begin r = 13'(prow); c = acc_next; done = 1'b1; end
        end
      end
      PH_SCR: begin
        if (b == ChGt || b == 8'h00) begin
          done = 1'b1;
        end else begin
          if (flen >= 3'd4 || word_chr(3'd3, flen) != b) wflags_next[0] = 1'b0;
          if (flen >= 3'd5 || word_chr(3'd4, flen) != b) wflags_next[1] = 1'b0;
          if (flen < 3'd7) flen_next = flen + 3'd1;
          done = eom;
        end
        if (done) begin
          if (wflags_next[0] && flen_next == 3'd4) begin
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdScrollLeft, last: 1'b0}; n++;
          end else if (wflags_next[1] && flen_next == 3'd5) begin
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: CmdScrollRight, last: 1'b0}; n++;
          end
          phase_next = PH_DISCARD;
        end
        done = 1'b0;
      end
      PH_TEXT: begin
        if (b == 8'h00) begin
          phase_next = PH_DISCARD;
        end else begin
          if (ccol >= CW'(COLUMNS)) begin
            ccol_next = '0;
            crow_next = (ROWS == 1) ? 2'd0 :
                        ((crow == 2'(ROWS - 1)) ? 2'd0 : crow + 2'd1);
            addr = CmdAddrBase + (crow_next[0] ? OddRowOffset : 8'd0)
                 + (crow_next[1] ? 8'(COLUMNS) : 8'd0);
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: addr, last: 1'b0}; n++;
          end
          if (b >= ChSpace && b <= ChTilde) begin
            bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b1, value: b, last: 1'b0}; n++;
            ccol_next = ccol_next + CW'(1);
          end
        end
      end
      default: ;
    endcase

    // position write for line/column phases, negative fields clamp to zero, large ones to the last row/column
    if ((phase == PH_LINE || phase == PH_COL) && done) begin
      if (r < 13'sd0) r = '0;
      if (r > 13'(ROWS - 1)) r = 13'(ROWS - 1);
      if (c < 13'sd0) c = '0;
      if (c > 13'(COLUMNS - 1)) c = 13'(COLUMNS - 1);
      crow_next = r[1:0];
      ccol_next = CW'(c);
      addr = CmdAddrBase + (r[0] ? OddRowOffset : 8'd0)
           + (r[1] ? 8'(COLUMNS) : 8'd0) + 8'(c);
      bt.vld[n] = 1'b1; bt.wr[n] = '{rs: 1'b0, value: addr, last: 1'b0}; n++;
    end

    if (n > 0) bt.wr[n-1].last = 1'b1;

    if (eom) begin
      phase_next = PH_PREFIX; pcount_next = '0; flen_next = '0; acc_next = '0;
      prow_next = '0; wflags_next = 2'b11; crow_next = '0; ccol_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREFIX;
      pcount <= '0; flen <= '0; acc <= '0; prow <= '0;
      wflags <= 2'b11; crow <= '0; ccol <= '0;
      bvld <= 1'b0;
    end else begin
      if (bvld && b_ready) bvld <= 1'b0;
      if (in_valid && in_ready) begin
        phase <= phase_next;
        pcount <= pcount_next; flen <= flen_next; acc <= acc_next;
        prow <= prow_next; wflags <= wflags_next;
        crow <= crow_next; ccol <= ccol_next;
        bvld <= |bt.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < 5; i++) pstore[i] <= pstore_next[i];
      b_data <= bt;
    end
  end

endmodule

>>> hdl/tclw_back.sv
module tclw_back import tclw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       b_valid,
  output logic       b_ready,
  input  batch_t     b_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       register_select,
  output logic [3:0] nibble,
  output logic       high_half,
  output logic       last_in_run
);

  localparam int QD = 2;

  batch_t    q [QD];
  logic      qwp, qrp;
  logic [1:0] qcnt;
  logic [MaxWrites-1:0] done_mask;
  logic      half;
  logic      ovld;
  logic [MaxWrites-1:0] pend;
  logic [$clog2(MaxWrites)-1:0] sel;
  logic      last_wr, adv;

  assign b_ready = (qcnt != 2'(QD));
  assign pend = q[qrp].vld & ~done_mask;

  always_comb begin
    sel = '0;
    for (int i = MaxWrites - 1; i >= 0; i--) if (pend[i]) sel = ($clog2(MaxWrites))'(i);
    last_wr = ((pend & ~(MaxWrites'(1) << sel)) == '0);
  end

  assign adv = (qcnt != 2'd0) && (!ovld || out_ready);
  assign out_valid = ovld;

  always_ff @(posedge clk) begin
    if (rst) begin
      qwp <= 1'b0; qrp <= 1'b0; qcnt <= '0;
      done_mask <= '0; half <= 1'b1; ovld <= 1'b0;
    end else begin
      if (ovld && out_ready) ovld <= 1'b0;
      if (adv) begin
        ovld <= 1'b1;
        half <= !half;
        if (!half) begin
          if (last_wr) done_mask <= '0;
          else done_mask <= done_mask | (MaxWrites'(1) << sel);
        end
      end
      if (b_valid && b_ready) qwp <= !qwp;
      if (adv && !half && last_wr) qrp <= !qrp;
      qcnt <= qcnt + 2'(b_valid && b_ready) - 2'(adv && !half && last_wr);
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) q[qwp] <= b_data;
    if (adv) begin
      register_select <= q[qrp].wr[sel].rs;
      nibble <= half ? q[qrp].wr[sel].value[7:4] : q[qrp].wr[sel].value[3:0];
      high_half <= half;
      last_in_run <= !half && q[qrp].wr[sel].last;
    end
  end

endmodule

>>> hdl/text_command_lcd_nibble_writer_unit.sv
// A byte's display writes pass the parser's batch register, the write queue
// and the output nibble register. One nibble per cycle on the output while writes
// are queued and out_ready holds; a byte causes 0 to 6 display writes (0 to 12 nibbles).
// The parser takes a byte every cycle while the 2-entry write queue has room.
// Reset (rst, synchronous): parser back to prefix collection, cursor 0,0,
// queue and output emptied.
module text_command_lcd_nibble_writer_unit import tclw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS = DefRows
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       register_select,
  output logic [3:0] nibble,
  output logic       high_half,
  output logic       last_in_run
);

  // front: parse bytes into up to six display writes per beat
  logic   b_valid, b_ready;
  batch_t b_data;

  tclw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .end_of_message,
    .b_valid, .b_ready, .b_data
  );

  // back: queue of write batches, split into nibbles high half first
  tclw_back u_back (
    .clk, .rst, .b_valid, .b_ready, .b_data,
    .out_valid, .out_ready, .register_select, .nibble, .high_half, .last_in_run
  );

endmodule

>>> hdl/tclw_checker.sv
module tclw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       high_half,
  input logic       last_in_run
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(high_half)) else $error("out stall");

  a_last_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_in_run |-> !high_half) else $error("last on high half");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && high_half |=> out_valid && !high_half)
    else $error("low half missing");

endmodule

bind text_command_lcd_nibble_writer_unit tclw_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .high_half, .last_in_run
);
